/* rtl/lpsb_pkg.sv */
// Shared types and constants for the lidar point scan binner.
package lpsb_pkg;

	// Field widths
	localparam int unsigned ANGLE_W    = 16;
	localparam int unsigned DIST_W     = 16;
	localparam int unsigned INTEN_W    = 8;
	localparam int unsigned COUNT_W    = 10;
	localparam int unsigned BIN_OUT_W  = 9;
	localparam int unsigned CORR_OUT_W = 18;
	localparam int unsigned ROT_CFG_W  = 17;
	localparam int unsigned CORR_CFG_W = 11;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 17;

	// Defaults for top-level parameters
	localparam int unsigned DEF_MAX_BEAMS = 512;
	localparam int unsigned DEF_OUT_DEPTH = 8;

	// Scan epoch kept with each bin entry
	localparam int unsigned EPOCH_W = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

	// Angle wrap and bin arithmetic
	localparam int unsigned ROT_SUM_W = 18;
	localparam int unsigned WRAP_W    = 17;
	localparam logic signed [ROT_SUM_W-1:0] TURN_S = 18'sd36000;
	localparam int unsigned PROD_W      = 27;
	localparam int unsigned CEIL_ADD    = 35999;
	// x / 36000 = (x >> 5) / 1125, the latter as multiply by ceil(2^34 / 1125)
	localparam int unsigned PRE_SHIFT   = 5;
	localparam int unsigned RECIP_MULT  = 15270995;
	localparam int unsigned RECIP_SHIFT = 34;
	localparam int unsigned QP_W        = 46;
	localparam int unsigned QUOT_W      = QP_W - RECIP_SHIFT;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROTATION   = 3'd0,
		CFG_CORRECTION = 3'd1,
		CFG_SCAN_CCW   = 3'd2,
		CFG_CROP_EN    = 3'd3,
		CFG_CROP_MIN   = 3'd4,
		CFG_CROP_MAX   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic signed [ROT_CFG_W-1:0]  rotation;
		logic signed [CORR_CFG_W-1:0] correction;
		logic                         scan_ccw;
		logic                         crop_en;
		logic [ANGLE_W-1:0]           crop_min;
		logic [ANGLE_W-1:0]           crop_max;
	} cfg_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic [DIST_W-1:0]  dist_mm;
		logic [INTEN_W-1:0] inten;
		logic [COUNT_W-1:0] count;
		logic [EPOCH_W-1:0] epoch;
	} point_t;

	typedef struct packed {
		logic [COUNT_W-1:0] bin;
		logic               point_ok;
		logic [DIST_W-1:0]  dist_mm;
		logic [INTEN_W-1:0] inten;
		logic [EPOCH_W-1:0] epoch;
	} bin_item_t;

	typedef struct packed {
		logic [BIN_OUT_W-1:0]         bin_index;
		logic                         range_written;
		logic                         range_valid;
		logic [DIST_W-1:0]            range_mm;
		logic signed [CORR_OUT_W-1:0] corrected_range_mm;
		logic                         intensity_valid;
		logic [INTEN_W-1:0]           intensity_out;
	} result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sweep_stat_t;

endpackage

/* rtl/lpsb_bin_calc.sv */
// Point validity, angle wrap and bin index pipeline (four stages).
module lpsb_bin_calc import lpsb_pkg::*; #(
	parameter int unsigned MAX_BEAMS = DEF_MAX_BEAMS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  point_t    point,
	input  cfg_t      cfg,
	output logic      item_valid,
	output bin_item_t item,
	output logic      drop
);

	typedef struct packed {
		logic [COUNT_W-1:0] nm1;
		logic               point_ok;
		logic [DIST_W-1:0]  dist_mm;
		logic [INTEN_W-1:0] inten;
		logic [EPOCH_W-1:0] epoch;
	} carry_t;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	point_t pt_s1;
	carry_t c_w, c_s2, c_s3, c_s4;

	logic                        crop_hit_w;
	logic signed [ROT_SUM_W-1:0] sum_w, hi_w, lo_w;
	logic [WRAP_W-1:0]           rot_w, rot_s2;
	logic                        neg_w, neg_s2, neg_s3, neg_s4;
	logic [PROD_W-1:0]           prod_w, prod_s3, ceil_w;
	logic [QP_W-1:0]             qp_w;
	logic [QUOT_W-1:0]           quot_s4;
	logic                        over_w;

	// s1: validity, clamp of count, rotation with one wrap
	always_comb begin
		crop_hit_w = cfg.crop_en && (pt_s1.angle >= cfg.crop_min) &&
			(pt_s1.angle <= cfg.crop_max);
		c_w.point_ok = (pt_s1.dist_mm != '0) && !crop_hit_w;
		c_w.dist_mm  = pt_s1.dist_mm;
		c_w.inten    = pt_s1.inten;
		c_w.epoch    = pt_s1.epoch;
		if (pt_s1.count < COUNT_W'(2)) begin
			c_w.nm1 = COUNT_W'(1);
		end else if (32'(pt_s1.count) > 32'(MAX_BEAMS)) begin
			c_w.nm1 = COUNT_W'(MAX_BEAMS - 1);
		end else begin
			c_w.nm1 = pt_s1.count - COUNT_W'(1);
		end

		sum_w = $signed({2'b00, pt_s1.angle}) + {cfg.rotation[ROT_CFG_W-1], cfg.rotation};
		hi_w  = sum_w - TURN_S;
		lo_w  = sum_w + TURN_S;
		if (sum_w >= TURN_S) begin
			rot_w = hi_w[WRAP_W-1:0];
			neg_w = 1'b0;
		end else if (sum_w < 0) begin
			rot_w = lo_w[WRAP_W-1:0];
			neg_w = lo_w[ROT_SUM_W-1];
		end else begin
			rot_w = sum_w[WRAP_W-1:0];
			neg_w = 1'b0;
		end
	end

	// s2: angle times (count - 1)
	assign prod_w = PROD_W'(rot_s2) * PROD_W'(c_s2.nm1);

	// s3: ceil divide by a full turn
	assign ceil_w = prod_s3 + PROD_W'(CEIL_ADD);
	assign qp_w   = QP_W'(ceil_w[PROD_W-1:PRE_SHIFT]) * QP_W'(RECIP_MULT);

	// s4: range check and mirror
	assign over_w     = neg_s4 || (quot_s4 > QUOT_W'(c_s4.nm1));
	assign item_valid = valid_s4 && !over_w;
	assign drop       = valid_s4 && over_w;

	always_comb begin
		item.point_ok = c_s4.point_ok;
		item.dist_mm  = c_s4.dist_mm;
		item.inten    = c_s4.inten;
		item.epoch    = c_s4.epoch;
		if (cfg.scan_ccw) begin
			item.bin = c_s4.nm1 - quot_s4[COUNT_W-1:0];
		end else begin
			item.bin = quot_s4[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pt_s1 <= point;
		end
		c_s2    <= c_w;
		rot_s2  <= rot_w;
		neg_s2  <= neg_w;
		c_s3    <= c_s2;
		prod_s3 <= prod_w;
		neg_s3  <= neg_s2;
		c_s4    <= c_s3;
		quot_s4 <= qp_w[QP_W-1:RECIP_SHIFT];
		neg_s4  <= neg_s3;
	end

endmodule

/* rtl/lpsb_bin_store.sv */
// Bin range memory with read-modify-write, forwarding and clearing sweep.
module lpsb_bin_store import lpsb_pkg::*; #(
	parameter int unsigned MAX_BEAMS = DEF_MAX_BEAMS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  bin_item_t                    item,
	input  logic signed [CORR_CFG_W-1:0] correction,
	input  logic                         sweep_start,
	output sweep_stat_t                  sweep_stat,
	output logic                         res_valid,
	output result_t                      res
);

	localparam int unsigned ADDR_W = $clog2(MAX_BEAMS);

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic               ok;
		logic [DIST_W-1:0]  range;
	} entry_t;

	entry_t mem [MAX_BEAMS];

	logic [ADDR_W-1:0] rd_addr_w, addr_s5, wr_addr_w, sweep_addr_q, fwd_addr_q;
	entry_t            rd_data_s5, entry_w, wr_data_w, fwd_data_q;
	logic              valid_s5, fwd_valid_q, sweep_q, sweep_last_w;
	bin_item_t         item_s5;
	logic              stored_ok_w, write_w, wr_en_w, rv_w;
	logic signed [CORR_OUT_W-1:0] corr_w;

	assign rd_addr_w = ADDR_W'(item.bin);

	// previous-cycle write to the same bin is newer than the memory read
	assign entry_w = (fwd_valid_q && (fwd_addr_q == addr_s5)) ? fwd_data_q : rd_data_s5;

	assign stored_ok_w = entry_w.ok && (entry_w.epoch == item_s5.epoch);
	assign write_w     = !stored_ok_w || (item_s5.point_ok && (item_s5.dist_mm < entry_w.range));
	assign rv_w        = write_w && item_s5.point_ok;

	assign sweep_last_w = (sweep_addr_q == ADDR_W'(MAX_BEAMS - 1));

	always_comb begin
		if (sweep_q) begin
			wr_en_w   = 1'b1;
			wr_addr_w = sweep_addr_q;
			wr_data_w = '0;
		end else begin
			wr_en_w         = valid_s5 && write_w;
			wr_addr_w       = addr_s5;
			wr_data_w.epoch = item_s5.epoch;
			wr_data_w.ok    = item_s5.point_ok;
			wr_data_w.range = item_s5.point_ok ? item_s5.dist_mm : '0;
		end
	end

	assign corr_w = $signed({2'b00, item_s5.dist_mm}) +
		{{(CORR_OUT_W - CORR_CFG_W){correction[CORR_CFG_W-1]}}, correction};

	always_comb begin
		res.bin_index          = item_s5.bin[BIN_OUT_W-1:0];
		res.range_written      = write_w;
		res.range_valid        = rv_w;
		res.range_mm           = rv_w ? item_s5.dist_mm : '0;
		res.corrected_range_mm = rv_w ? corr_w : '0;
		res.intensity_valid    = item_s5.point_ok;
		res.intensity_out      = item_s5.point_ok ? item_s5.inten : '0;
	end

	assign res_valid       = valid_s5;
	assign sweep_stat.busy = sweep_q;
	assign sweep_stat.done = sweep_q && sweep_last_w;

	always_ff @(posedge clk) begin
		if (item_valid) begin
			rd_data_s5 <= mem[rd_addr_w];
		end
		if (wr_en_w) begin
			mem[wr_addr_w] <= wr_data_w;
		end
	end

	always_ff @(posedge clk) begin
		item_s5    <= item;
		addr_s5    <= rd_addr_w;
		fwd_addr_q <= wr_addr_w;
		fwd_data_q <= wr_data_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5     <= 1'b0;
			fwd_valid_q  <= 1'b0;
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
		end else begin
			valid_s5    <= item_valid;
			fwd_valid_q <= wr_en_w;
			if (sweep_q) begin
				if (sweep_last_w) begin
					sweep_q      <= 1'b0;
					sweep_addr_q <= '0;
				end else begin
					sweep_addr_q <= sweep_addr_q + ADDR_W'(1);
				end
			end else if (sweep_start) begin
				sweep_q      <= 1'b1;
				sweep_addr_q <= '0;
			end
		end
	end

`ifndef SYNTH
	a_no_rmw_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!(sweep_q && valid_s5))
		else $error("bin update overlaps clearing sweep");

	a_no_read_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid |-> !sweep_q)
		else $error("bin read issued during clearing sweep");
`endif

endmodule

/* rtl/lpsb_out_fifo.sv */
// Result queue between the bin update stage and the output channel.
module lpsb_out_fifo import lpsb_pkg::*; #(
	parameter int unsigned DEPTH = DEF_OUT_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  result_t                    push_data,
	input  logic                       pop,
	output result_t                    head,
	output logic                       not_empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	result_t           slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign head      = slot_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (count_q < CNT_W'(DEPTH)))
		else $error("result queue overflow");
`endif

endmodule

/* rtl/lidar_point_scan_binner.sv */
// Top level of the lidar point scan binner: config, scan epoch, credits.
//
// Channel   Handshake              Payload
// -------   --------------------   ---------------------------------------------
// in        in_valid / in_ready    angle_centideg, distance_mm, intensity,
//                                  point_count, first_of_scan
// out       out_valid / out_ready  bin_index, range_written, range_valid,
//                                  range_mm, corrected_range_mm,
//                                  intensity_valid, intensity_out
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// One point per cycle sustained while in_ready is high; a point passes the bin calc
// stages and the bin update stage, then enters the result queue, and out_valid rises
// with that entry. The bin memory read-modify-write sets the rate.
// After reset a clearing sweep over all MAX_BEAMS bins runs with in_ready low.
// The same sweep runs once every 2^EPOCH_W scans, on the wrapping first point,
// after the pipeline has drained.
// Output stalls fill the result queue; in_ready drops when OUT_DEPTH points
// are in flight. Points dropped for an out-of-range bin return their credit.
module lidar_point_scan_binner import lpsb_pkg::*; #(
	parameter int unsigned MAX_BEAMS = DEF_MAX_BEAMS,
	parameter int unsigned OUT_DEPTH = DEF_OUT_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ANGLE_W-1:0]           angle_centideg,
	input  logic [DIST_W-1:0]            distance_mm,
	input  logic [INTEN_W-1:0]           intensity,
	input  logic [COUNT_W-1:0]           point_count,
	input  logic                         first_of_scan,

	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [BIN_OUT_W-1:0]         bin_index,
	output logic                         range_written,
	output logic                         range_valid,
	output logic [DIST_W-1:0]            range_mm,
	output logic signed [CORR_OUT_W-1:0] corrected_range_mm,
	output logic                         intensity_valid,
	output logic [INTEN_W-1:0]           intensity_out,

	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

	cfg_t               cfg_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               swept_q;
	logic [CNT_W-1:0]   in_flight_q, fifo_count;

	logic        in_fire, out_fire, wrap_hold, pipe_busy, sweep_start;
	point_t      point_w;
	logic        item_valid, drop, res_valid;
	bin_item_t   item;
	result_t     res, head;
	sweep_stat_t sweep_stat;

	// A first point that would reuse an epoch waits for a full clearing sweep
	assign wrap_hold   = first_of_scan && (epoch_q == EPOCH_MAX) && !swept_q;
	assign pipe_busy   = (in_flight_q != fifo_count);
	assign sweep_start = in_valid && wrap_hold && !sweep_stat.busy && !pipe_busy;

	assign in_ready  = !sweep_stat.busy && !wrap_hold && (in_flight_q < CNT_W'(OUT_DEPTH));
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;
	assign cfg_ready = 1'b1;

	// New scan takes the next epoch; bins of older epochs read as empty
	always_comb begin
		point_w.angle   = angle_centideg;
		point_w.dist_mm = distance_mm;
		point_w.inten   = intensity;
		point_w.count   = point_count;
		point_w.epoch   = first_of_scan ? epoch_q + EPOCH_W'(1) : epoch_q;
	end

	lpsb_bin_calc #(
		.MAX_BEAMS (MAX_BEAMS)
	) u_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.point      (point_w),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.drop       (drop)
	);

	lpsb_bin_store #(
		.MAX_BEAMS (MAX_BEAMS)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item        (item),
		.correction  (cfg_q.correction),
		.sweep_start (sweep_start),
		.sweep_stat  (sweep_stat),
		.res_valid   (res_valid),
		.res         (res)
	);

	lpsb_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (out_fire),
		.head      (head),
		.not_empty (out_valid),
		.count     (fifo_count)
	);

	assign bin_index          = head.bin_index;
	assign range_written      = head.range_written;
	assign range_valid        = head.range_valid;
	assign range_mm           = head.range_mm;
	assign corrected_range_mm = head.corrected_range_mm;
	assign intensity_valid    = head.intensity_valid;
	assign intensity_out      = head.intensity_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotation   <= '0;
			cfg_q.correction <= '0;
			cfg_q.scan_ccw   <= 1'b1;
			cfg_q.crop_en    <= 1'b0;
			cfg_q.crop_min   <= '0;
			cfg_q.crop_max   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROTATION:   cfg_q.rotation   <= $signed(cfg_data[ROT_CFG_W-1:0]);
				CFG_CORRECTION: cfg_q.correction <= $signed(cfg_data[CORR_CFG_W-1:0]);
				CFG_SCAN_CCW:   cfg_q.scan_ccw   <= cfg_data[0];
				CFG_CROP_EN:    cfg_q.crop_en    <= cfg_data[0];
				CFG_CROP_MIN:   cfg_q.crop_min   <= cfg_data[ANGLE_W-1:0];
				CFG_CROP_MAX:   cfg_q.crop_max   <= cfg_data[ANGLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q     <= '0;
			swept_q     <= 1'b0;
			in_flight_q <= '0;
		end else begin
			if (in_fire && first_of_scan) begin
				epoch_q <= epoch_q + EPOCH_W'(1);
				swept_q <= 1'b0;
			end else if (sweep_stat.done) begin
				swept_q <= 1'b1;
			end
			in_flight_q <= in_flight_q + CNT_W'(in_fire) - CNT_W'(out_fire) - CNT_W'(drop);
		end
	end

`ifndef SYNTH
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q <= CNT_W'(OUT_DEPTH))
		else $error("points in flight exceed result queue depth");

	a_result_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (in_flight_q >= fifo_count) && (in_flight_q != '0))
		else $error("result present without an outstanding point");

	a_sweep_drained: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_start |-> (!item_valid && !res_valid && !in_fire))
		else $error("sweep started with points in the pipeline");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for lidar_point_scan_binner: predicts every bin update and checks it.
`timescale 1ns / 100ps

module tb_top;
	import lpsb_pkg::*;

	// Geometry and run limits
	localparam int unsigned MAX_BEAMS     = DEF_MAX_BEAMS;
	localparam int unsigned SETTLE_CYCLES = 16;      // lets the pipeline drain; dropped points leave no trace
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned TURN          = 36000;   // one revolution in centidegrees

	// Register indexes past the last real register; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic [DIST_W-1:0]  dist_mm;
		logic [INTEN_W-1:0] inten;
		logic [COUNT_W-1:0] count;
		logic               first;
	} point_in_t;

	// DUT ports, all driven to known values from time zero
	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [ANGLE_W-1:0]           angle_centideg = '0;
	logic [DIST_W-1:0]            distance_mm = '0;
	logic [INTEN_W-1:0]           intensity = '0;
	logic [COUNT_W-1:0]           point_count = '0;
	logic                         first_of_scan = 1'b0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [BIN_OUT_W-1:0]         bin_index;
	logic                         range_written;
	logic                         range_valid;
	logic [DIST_W-1:0]            range_mm;
	logic signed [CORR_OUT_W-1:0] corrected_range_mm;
	logic                         intensity_valid;
	logic [INTEN_W-1:0]           intensity_out;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [CFG_IDX_W-1:0]         cfg_index = '0;
	logic [CFG_DATA_W-1:0]        cfg_data = '0;

	// Predictor state: register copy, per-bin minimum range, pending bin updates
	cfg_t              cfg_shadow;
	bit                bin_filled [MAX_BEAMS];
	logic [DIST_W-1:0] bin_range  [MAX_BEAMS];
	result_t           expected_updates [$];

	// Traffic shaping, set per test
	int idle_pct  = 0;   // chance per cycle that the sender holds back
	int stall_pct = 0;   // chance per cycle that the receiver stalls
	int hold_left = 0;   // long receiver hold-off, counted down by the receiver

	// Bookkeeping
	int unsigned points_sent     = 0;
	int unsigned updates_checked = 0;
	int unsigned points_dropped  = 0;
	int unsigned scans_started   = 0;
	int unsigned mismatches      = 0;
	int unsigned cycle_count     = 0;

	lidar_point_scan_binner DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.angle_centideg     (angle_centideg),
		.distance_mm        (distance_mm),
		.intensity          (intensity),
		.point_count        (point_count),
		.first_of_scan      (first_of_scan),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.bin_index          (bin_index),
		.range_written      (range_written),
		.range_valid        (range_valid),
		.range_mm           (range_mm),
		.corrected_range_mm (corrected_range_mm),
		.intensity_valid    (intensity_valid),
		.intensity_out      (intensity_out),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	always #4 clk = ~clk;

	// Hard stop: a lost result or a hung handshake ends up here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off when a test loads hold_left
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic note_mismatch(input string what, input result_t want, input result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t %s: expected bin %0d wr %b rv %b range %0d corr %0d iv %b int %0d",
				$time, what,
				want.bin_index, want.range_written, want.range_valid, want.range_mm,
				want.corrected_range_mm, want.intensity_valid, want.intensity_out);
			$display("%0t %s: got      bin %0d wr %b rv %b range %0d corr %0d iv %b int %0d",
				$time, what,
				got.bin_index, got.range_written, got.range_valid, got.range_mm,
				got.corrected_range_mm, got.intensity_valid, got.intensity_out);
		end
	endtask

	// Result checker: every output transaction against the oldest pending update
	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			got.bin_index          = bin_index;
			got.range_written      = range_written;
			got.range_valid        = range_valid;
			got.range_mm           = range_mm;
			got.corrected_range_mm = corrected_range_mm;
			got.intensity_valid    = intensity_valid;
			got.intensity_out      = intensity_out;
			if (expected_updates.size() == 0) begin
				note_mismatch("bin update with none pending", '0, got);
			end else begin
				want = expected_updates.pop_front();
				updates_checked++;
				if (got.bin_index !== want.bin_index ||
				    got.range_written !== want.range_written ||
				    got.range_valid !== want.range_valid ||
				    got.range_mm !== want.range_mm ||
				    got.corrected_range_mm !== want.corrected_range_mm ||
				    got.intensity_valid !== want.intensity_valid ||
				    got.intensity_out !== want.intensity_out)
					note_mismatch("bin update mismatch", want, got);
			end
		end
	end

	// Register write as seen by the predictor; unknown indexes fall through
	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_ROTATION:   cfg_shadow.rotation   = data[ROT_CFG_W-1:0];
			CFG_CORRECTION: cfg_shadow.correction = data[CORR_CFG_W-1:0];
			CFG_SCAN_CCW:   cfg_shadow.scan_ccw   = data[0];
			CFG_CROP_EN:    cfg_shadow.crop_en    = data[0];
			CFG_CROP_MIN:   cfg_shadow.crop_min   = data[ANGLE_W-1:0];
			CFG_CROP_MAX:   cfg_shadow.crop_max   = data[ANGLE_W-1:0];
			default: ;
		endcase
	endtask

	// Bin update for one accepted point; dropped points update nothing but the scan tag
	task automatic predict_bin_update(input point_in_t p);
		int unsigned       n;
		int                rot;
		int                corr;
		longint            quot;
		int unsigned       bin;
		bit                point_ok;
		bit                replace;
		result_t           upd;
		// a new scan empties every bin, even when this point is then dropped
		if (p.first) begin
			foreach (bin_filled[i])
				bin_filled[i] = 1'b0;
			scans_started++;
		end
		n = 32'(p.count);
		if (n < 2)
			n = 2;
		if (n > MAX_BEAMS)
			n = MAX_BEAMS;
		point_ok = (p.dist_mm != 0);
		if (cfg_shadow.crop_en && p.angle >= cfg_shadow.crop_min &&
		    p.angle <= cfg_shadow.crop_max)
			point_ok = 1'b0;
		// single wrap each way; out-of-range angle or rotation can still miss
		rot = int'(p.angle) + int'($signed(cfg_shadow.rotation));
		if (rot >= int'(TURN))
			rot -= TURN;
		if (rot < 0)
			rot += TURN;
		if (rot < 0) begin
			points_dropped++;
			return;
		end
		quot = (longint'(rot) * longint'(n - 1) + longint'(TURN - 1)) / longint'(TURN);
		if (quot >= longint'(n)) begin
			points_dropped++;
			return;
		end
		bin = 32'(quot);
		if (cfg_shadow.scan_ccw)
			bin = n - 1 - bin;
		// keep the per-scan minimum; an empty bin takes anything, even a bad point
		replace = !bin_filled[bin] || (point_ok && p.dist_mm < bin_range[bin]);
		upd = '0;
		upd.bin_index     = bin[BIN_OUT_W-1:0];
		upd.range_written = replace;
		if (replace) begin
			bin_filled[bin] = point_ok;
			bin_range[bin]  = point_ok ? p.dist_mm : '0;
			if (point_ok) begin
				corr = int'(p.dist_mm) + int'($signed(cfg_shadow.correction));
				upd.range_valid        = 1'b1;
				upd.range_mm           = p.dist_mm;
				upd.corrected_range_mm = corr[CORR_OUT_W-1:0];
			end
		end
		upd.intensity_valid = point_ok;
		upd.intensity_out   = point_ok ? p.inten : '0;
		expected_updates.push_back(upd);
	endtask

	// One input transaction; called and returns at a falling edge, in_valid left high
	task automatic send_point(input point_in_t p);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		angle_centideg <= p.angle;
		distance_mm    <= p.dist_mm;
		intensity      <= p.inten;
		point_count    <= p.count;
		first_of_scan  <= p.first;
		do
			@(posedge clk);
		while (!in_ready);
		predict_bin_update(p);
		points_sent++;
		@(negedge clk);
	endtask

	// Sender pause: all pending updates in, pipeline settled, no clearing sweep running
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_updates.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// All six registers; unused data bits are randomized to check the masking
	task automatic write_all_regs(input logic signed [ROT_CFG_W-1:0] rot,
			input logic signed [CORR_CFG_W-1:0] corr, input bit ccw, input bit crop_en,
			input logic [ANGLE_W-1:0] crop_min, input logic [ANGLE_W-1:0] crop_max);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		write_reg(CFG_ROTATION, rot);
		write_reg(CFG_CORRECTION, {junk[CFG_DATA_W-1:CORR_CFG_W], corr});
		write_reg(CFG_SCAN_CCW, {junk[CFG_DATA_W-1:1], ccw});
		write_reg(CFG_CROP_EN, {junk[CFG_DATA_W-2:0], crop_en});
		write_reg(CFG_CROP_MIN, {junk[0], crop_min});
		write_reg(CFG_CROP_MAX, {junk[1], crop_max});
		if ($urandom_range(1))
			write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI,
				CFG_DATA_W'($urandom));
	endtask

	task automatic write_random_regs();
		int                    rot;
		logic [ANGLE_W-1:0]    cmin;
		logic [ANGLE_W-1:0]    cmax;
		// mostly a sane mount rotation, sometimes anything the field holds
		if ($urandom_range(4) == 0)
			rot = int'($urandom_range(131071));
		else
			rot = int'($urandom_range(2 * (TURN - 1))) - int'(TURN - 1);
		if ($urandom_range(5) == 0) begin
			cmin = ANGLE_W'($urandom);
			cmax = ANGLE_W'($urandom);
		end else begin
			cmin = ANGLE_W'($urandom_range(TURN - 1));
			cmax = cmin + ANGLE_W'($urandom_range(4000));
		end
		write_all_regs(ROT_CFG_W'(rot), CORR_CFG_W'($urandom), 1'($urandom_range(1)),
			1'($urandom_range(1)), cmin, cmax);
	endtask

	function automatic point_in_t make_point(input int unsigned angle, input int unsigned dist_mm,
			input int unsigned inten, input int unsigned count, input bit first);
		point_in_t p;
		p.angle   = ANGLE_W'(angle);
		p.dist_mm = DIST_W'(dist_mm);
		p.inten   = INTEN_W'(inten);
		p.count   = COUNT_W'(count);
		p.first   = first;
		return p;
	endfunction

	function automatic int unsigned random_dist();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 15)
			return 0;
		if (pick < 65)
			return $urandom_range(1, 3000);   // narrow spread so the minimum logic works hard
		return $urandom_range(1, 65535);
	endfunction

	// Anything the fields can carry
	function automatic point_in_t noise_point();
		return make_point($urandom_range(65535), $urandom_range(65535), $urandom_range(255),
			$urandom_range(1023), ($urandom_range(9) == 0));
	endfunction

	// One well-formed scan: first point flagged, angles sweeping, then a few revisits
	task automatic send_scan();
		int unsigned pick;
		int unsigned raw_n;
		int unsigned n;
		int unsigned pts;
		int unsigned ang;
		pick = $urandom_range(99);
		if (pick < 80)
			raw_n = $urandom_range(2, 16);
		else if (pick < 95)
			raw_n = $urandom_range(17, MAX_BEAMS);
		else
			raw_n = $urandom_range(1) ? $urandom_range(1) : $urandom_range(MAX_BEAMS + 1, 1023);
		n = (raw_n < 2) ? 2 : (raw_n > MAX_BEAMS) ? MAX_BEAMS : raw_n;
		pts = n + $urandom_range(n);
		if (pts > 24)
			pts = 24;
		for (int i = 0; i < pts; i++) begin
			if (i < n) begin
				ang = (i * TURN) / n + $urandom_range((TURN - 1) / n);
				if (ang > TURN - 1)
					ang = TURN - 1;
			end else begin
				ang = $urandom_range(TURN - 1);
			end
			send_point(make_point(ang, random_dist(), $urandom_range(255), raw_n, (i == 0)));
		end
	endtask

	// Extremes under reset config (counterclockwise mirror on, no rotation, no crop)
	task automatic test_directed_defaults();
		idle_pct  = 0;
		stall_pct = 26;
		send_point(make_point(0, 1000, 8'hA5, 0, 1'b1));       // count below 2 taken as 2
		send_point(make_point(0, 1500, 8'h01, 1, 1'b0));       // larger range keeps the bin
		send_point(make_point(0, 400, 8'h80, 2, 1'b0));        // smaller range replaces
		send_point(make_point(0, 0, 8'hFF, 2, 1'b0));          // no return: intensity invalid
		send_point(make_point(TURN - 1, 65535, 8'h5A, 2, 1'b0)); // top angle, top distance
		send_point(make_point(1, 0, 8'h33, MAX_BEAMS, 1'b1));  // bad point into an empty bin
		send_point(make_point(1, 7, 8'h44, MAX_BEAMS, 1'b0));  // bin still empty after that
		send_point(make_point(TURN / 2, 1, 8'h00, MAX_BEAMS, 1'b0));
		send_point(make_point(TURN - 1, 300, 8'hC3, 1023, 1'b0)); // count above the bin store
		send_point(make_point(32768, 16'h8000, 8'h3C, MAX_BEAMS + 1, 1'b0));
		send_point(make_point(65535, 12, 8'h0F, MAX_BEAMS, 1'b0)); // raw angle past a turn
		send_point(make_point(100, 65535, 8'hF0, 3, 1'b1));
		send_point(make_point(100, 65535, 8'h11, 3, 1'b0));    // equal range: no replace
		send_point(make_point(100, 65534, 8'h22, 3, 1'b0));
		wait_idle();
	endtask

	// Probe a register setting with crop edges, out-of-range angles and odd counts
	task automatic probe_setting();
		int unsigned probe_angle [10] =
			'{0, 65535, 35999, 9000, 8999, 9001, 20000, 10000, 32768, 18000};
		int unsigned probe_count [10] = '{0, 1, 2, 7, 512, 1023, 513, 360, 3, 100};
		for (int i = 0; i < 10; i++)
			send_point(make_point(probe_angle[i], (i % 4 == 3) ? 0 : $urandom_range(1, 65535),
				$urandom_range(255), probe_count[i], (i == 0 || i == 5)));
		wait_idle();
	endtask

	task automatic test_register_settings();
		idle_pct  = 26;
		stall_pct = 26;
		// crop window covers every legal angle
		write_all_regs(35999, 1023, 1'b0, 1'b1, 0, 35999);
		probe_setting();
		// single-angle crop window, most negative correction
		write_all_regs(-35999, -1024, 1'b1, 1'b1, 9000, 9000);
		probe_setting();
		// rotation beyond a turn the other way: new scan on a dropped point
		write_all_regs(-65536, -1000, 1'b0, 1'b1, 20000, 10000);
		probe_setting();
		write_all_regs(65535, 1000, 1'b1, 1'b0, 65535, 65535);
		probe_setting();
		write_reg(CFG_SPARE_LO, '1);
		write_reg(CFG_SPARE_HI, '1);
		write_all_regs(0, 0, 1'b1, 1'b0, 0, 0);
		probe_setting();
	endtask

	// Receiver holds off while the sender keeps pushing: credits run out, in_ready drops
	task automatic test_output_hold();
		idle_pct  = 0;
		stall_pct = 0;
		hold_left = 300;
		for (int i = 0; i < 40; i++)
			send_point(make_point($urandom_range(TURN - 1), random_dist(), $urandom_range(255),
				30, (i == 0)));
		wait_idle();
	endtask

	task automatic test_random_scans(input int idle, input int stall, input int unsigned n_items);
		int unsigned start;
		for (int half = 0; half < 2; half++) begin
			write_random_regs();
			idle_pct  = idle;
			stall_pct = stall;
			start = points_sent;
			while (points_sent - start < n_items / 2) begin
				if ($urandom_range(99) < 85)
					send_scan();
				else
					send_point(noise_point());
			end
			wait_idle();
		end
	endtask

	// Hundreds of one-point scans so the block's scan tag wraps and its clearing sweep runs
	task automatic test_scan_tag_wrap();
		idle_pct  = 0;
		stall_pct = 0;
		write_all_regs(4500, -25, 1'b0, 1'b0, 0, 0);
		for (int i = 0; i < 300; i++)
			send_point(make_point($urandom_range(TURN - 1), random_dist(), $urandom_range(255),
				$urandom_range(0, 8), 1'b1));
		wait_idle();
	endtask

	initial begin
		cfg_shadow          = '0;
		cfg_shadow.scan_ccw = 1'b1;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		wait_idle();   // also rides out the clearing sweep after reset

		test_directed_defaults();
		test_register_settings();
		test_output_hold();
		test_random_scans(0, 0, 400);
		test_random_scans(72, 0, 400);
		test_random_scans(0, 72, 400);
		test_random_scans(26, 26, 400);
		test_scan_tag_wrap();
		wait_idle();

		$display("summary: %0d points in, %0d bin updates checked, %0d points dropped, %0d scans",
			points_sent, updates_checked, points_dropped, scans_started);
		$display("summary: register extremes, crop edges, idle and stall mixes, long hold-off, tag wrap");
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
